// File: sv/gaussian_psf_splat_assert.svh
// Assertion macros for the point-source renderer.
`ifndef GAUSSIAN_PSF_SPLAT_ASSERT_SVH
`define GAUSSIAN_PSF_SPLAT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define GPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gaussian_psf_splat: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define GPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gaussian_psf_splat: next-cycle check failed");

`endif

// File: sv/gps_pkg.sv
// Package: types, constants and the exponent table of the point-source renderer.
package gps_pkg;

   localparam int IMG_W      = 64;
   localparam int IMG_H      = 64;
   localparam int MAX_RADIUS = 15;

   // Derived sizes
   localparam int ADDR_W    = $clog2(IMG_W * IMG_H);
   localparam int CRD_W     = 14;
   localparam int DX_W      = CRD_W + 9;
   localparam int AX_W      = $clog2((MAX_RADIUS + 1) * 256) + 1;
   localparam int D2_W      = 2 * AX_W + 1;
   localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
   localparam int WIN_DEPTH = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
   localparam int WIN_AW    = $clog2(WIN_DEPTH);
   localparam int WS_W      = $clog2(WIN_DEPTH * 65535 + 1);

   // Fixed-point constants
   localparam int RAD_PROD_W = 31;
   localparam logic [16:0] RADIUS_K_Q16 = 17'd83492;
   localparam logic [15:0] EXP_IDX_K    = 16'd45426;
   localparam int DEN_W   = 36;
   localparam int DIV_W   = 56;
   localparam int Q_W     = 24;
   localparam int CNT_W   = 5;
   localparam int EXP_AW  = 10;
   localparam int EXP_LEN = 1024;

   localparam logic OP_RENDER = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef enum logic [1:0] {
      ST_RENDERED = 2'd0,
      ST_BAD_ARG  = 2'd1,
      ST_OUTSIDE  = 2'd2,
      ST_READ     = 2'd3
   } status_type;

   typedef struct packed {
      logic               opcode;
      logic signed [19:0] x_centre;
      logic signed [19:0] y_centre;
      logic        [23:0] flux;
      logic        [13:0] fwhm_px;
      logic        [5:0]  read_col;
      logic        [5:0]  read_row;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_value;
      status_type  status;
   } rsp_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_READ, S_SETUP, S_WIN, S_CHK,
      S_P1_DXY, S_P1_SQX, S_P1_SQY, S_P1_NUM, S_P1_CHK, S_P1_DIV, S_P1_ROM, S_P1_ACC,
      S_P2_RD, S_P2_MUL, S_P2_DIVS, S_P2_DIV, S_P2_WR
   } state_type;

   typedef logic [15:0] exp_tab_type [EXP_LEN];

   // exp(-k/64) in Q0.16, built by repeated Q0.32 multiplication
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type t;
      logic [63:0] e;
      logic [63:0] v;
      e = 64'h1_0000_0000;
      for (int k = 0; k < EXP_LEN; k++) begin
         v = (e + 64'd32768) >> 16;
         t[k] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
         e = (e * 64'd4228380000 + 64'h8000_0000) >> 32;
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

// File: sv/gaussian_psf_splat.sv
// Top level: Gaussian point-source renderer over a 64x64 image memory.
//
// Usage: drive req_data with start high while busy is low; the item is taken at
// that edge. Every item gives exactly one result: rsp_valid is high for one cycle
// with rsp_data, and the receiver cannot stall it.
// A read item (opcode 1) returns one pixel, read as it is taken, from S_READ.
// A render item with zero flux or width answers from idle; one whose window
// misses the image answers from S_CHK. Otherwise the renderer walks the clipped
// window (up to 31x31 pixels) twice. Pass one, for each pixel: offset, two
// squares, scaling, then a 10-step serial divide for the exponent index (skipped
// when the index is past the table) and a table read. Pass two, for each pixel:
// the 24-step serial divide of flux*w by the weight sum, plus one read-modify-write
// of the image memory.
// After reset the image memory is cleared one pixel a cycle; busy stays high
// through that sweep. Results are registered along with the last write of their
// item, so a following read sees the new pixels.
module gaussian_psf_splat
   import gps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

`include "gaussian_psf_splat_assert.svh"

   localparam logic signed [CRD_W-1:0] IMG_W_S = CRD_W'(IMG_W);
   localparam logic signed [CRD_W-1:0] IMG_H_S = CRD_W'(IMG_H);

   state_type state_ff, state_in;

   // item registers
   logic signed [19:0]      xc_ff, xc_in, yc_ff, yc_in;
   logic [23:0]             flux_ff, flux_in;
   logic [13:0]             fw_ff, fw_in;
   logic                    oor_ff, oor_in;
   logic [RAD_PROD_W-1:0]   rad_prod_ff, rad_prod_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic signed [CRD_W-1:0] x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic signed [CRD_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [WIN_AW-1:0]       idx_ff, idx_in;
   logic [AX_W-1:0]         ax_ff, ax_in, ay_ff, ay_in;
   logic [2*AX_W-1:0]       sq_ff, sq_in;
   logic [D2_W-1:0]         d2_ff, d2_in;
   logic [DIV_W-1:0]        num_ff, num_in, dsh_ff, dsh_in;
   logic [Q_W-1:0]          q_ff, q_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    wzero_ff, wzero_in;
   logic [WS_W-1:0]         wsum_ff, wsum_in;
   logic [ADDR_W-1:0]       clr_ff, clr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   // memories and their read registers
   logic [31:0]       img_mem [IMG_W*IMG_H];
   logic [15:0]       w_mem [WIN_DEPTH];
   logic [31:0]       img_rd_ff;
   logic [15:0]       w_rd_ff;
   logic [15:0]       exp_rd_ff;
   logic              img_we, img_re, w_we;
   logic [ADDR_W-1:0] img_waddr, img_raddr, pix_addr, rd_addr;
   logic [31:0]       img_wdata;

   // shared combinational terms
   logic signed [CRD_W-1:0] cx, cy, r_ext;
   logic signed [DX_W-1:0]  dx, dy;
   logic [RAD_W+3:0]        r_ceil;
   logic [RAD_W-1:0]        r_val;
   logic [15:0]             w_sel;
   logic [WS_W-1:0]         wsum_next;
   logic                    last_col, last_pix, div_ge;
   logic [32:0]             sum_sat;
   logic                    accept, skip_arg;

   assign accept   = start && !busy;
   assign skip_arg = (req_data.flux == 24'd0) || (req_data.fwhm_px == 14'd0);

   // window geometry
   assign cx     = CRD_W'(xc_ff >>> 8);
   assign cy     = CRD_W'(yc_ff >>> 8);
   assign r_ceil = (RAD_W+4)'((rad_prod_ff + RAD_PROD_W'(24'hFFFFFF)) >> 24);
   assign r_val  = (r_ceil > (RAD_W+4)'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : RAD_W'(r_ceil);
   assign r_ext  = CRD_W'(rad_prod_ff == '0 ? '0 : r_val);

   // offsets from the source centre to this pixel centre
   assign dx = $signed({px_ff[CRD_W-1], px_ff, 8'h80}) - DX_W'(xc_ff);
   assign dy = $signed({py_ff[CRD_W-1], py_ff, 8'h80}) - DX_W'(yc_ff);

   assign pix_addr = ADDR_W'(py_ff) * ADDR_W'(IMG_W) + ADDR_W'(px_ff);
   assign rd_addr  = ADDR_W'(req_data.read_row) * ADDR_W'(IMG_W) + ADDR_W'(req_data.read_col);

   assign last_col  = (px_ff + CRD_W'(1)) == x1_ff;
   assign last_pix  = last_col && ((py_ff + CRD_W'(1)) == y1_ff);
   assign w_sel     = wzero_ff ? 16'd0 : exp_rd_ff;
   assign wsum_next = wsum_ff + WS_W'(w_sel);
   assign div_ge    = num_ff >= dsh_ff;
   assign sum_sat   = {1'b0, img_rd_ff} + 33'(q_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clr_ff == ADDR_W'(IMG_W*IMG_H-1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               priority if (req_data.opcode == OP_READ) state_in = S_READ;
               else if (skip_arg)                        state_in = S_IDLE;
               else                                      state_in = S_SETUP;
            end
         end
         S_READ:   state_in = S_IDLE;
         S_SETUP:  state_in = S_WIN;
         S_WIN:    state_in = S_CHK;
         S_CHK: begin
            if (x0_ff >= x1_ff || y0_ff >= y1_ff) state_in = S_IDLE;
            else                                   state_in = S_P1_DXY;
         end
         S_P1_DXY: state_in = S_P1_SQX;
         S_P1_SQX: state_in = S_P1_SQY;
         S_P1_SQY: state_in = S_P1_NUM;
         S_P1_NUM: state_in = S_P1_CHK;
         S_P1_CHK: state_in = (num_ff >= (DIV_W'(den_ff) << EXP_AW)) ? S_P1_ROM : S_P1_DIV;
         S_P1_DIV: begin
            if (cnt_ff == '0) state_in = S_P1_ROM;
         end
         S_P1_ROM: state_in = S_P1_ACC;
         S_P1_ACC: begin
            priority if (!last_pix)         state_in = S_P1_DXY;
            else if (wsum_next == '0)       state_in = S_IDLE;
            else                            state_in = S_P2_RD;
         end
         S_P2_RD:   state_in = S_P2_MUL;
         S_P2_MUL:  state_in = S_P2_DIVS;
         S_P2_DIVS: state_in = S_P2_DIV;
         S_P2_DIV: begin
            if (cnt_ff == '0) state_in = S_P2_WR;
         end
         S_P2_WR: state_in = last_pix ? S_IDLE : S_P2_RD;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      xc_in = xc_ff; yc_in = yc_ff; flux_in = flux_ff; fw_in = fw_ff; oor_in = oor_ff;
      rad_prod_in = rad_prod_ff; den_in = den_ff;
      x0_in = x0_ff; x1_in = x1_ff; y0_in = y0_ff; y1_in = y1_ff;
      px_in = px_ff; py_in = py_ff; idx_in = idx_ff;
      ax_in = ax_ff; ay_in = ay_ff; sq_in = sq_ff; d2_in = d2_ff;
      num_in = num_ff; dsh_in = dsh_ff; q_in = q_ff; cnt_in = cnt_ff;
      wzero_in = wzero_ff; wsum_in = wsum_ff; clr_in = clr_ff;
      rsp_valid_in = 1'b0;
      rsp_in = '{pixel_value: 32'd0, status: ST_RENDERED};
      img_we = 1'b0; img_waddr = pix_addr; img_wdata = 32'd0;
      img_re = 1'b0; img_raddr = pix_addr;
      w_we = 1'b0;

      // pixel walk, shared by both passes
      if (state_ff == S_P1_ACC || state_ff == S_P2_WR) begin
         idx_in = idx_ff + WIN_AW'(1);
         if (last_col) begin
            px_in = x0_ff;
            py_in = py_ff + CRD_W'(1);
         end else begin
            px_in = px_ff + CRD_W'(1);
         end
      end

      // restoring divide step, one quotient bit a cycle
      if (state_ff == S_P1_DIV || state_ff == S_P2_DIV) begin
         if (div_ge) num_in = num_ff - dsh_ff;
         q_in   = {q_ff[Q_W-2:0], div_ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
      end

      unique case (state_ff)
         S_CLEAR: begin
            img_we    = 1'b1;
            img_waddr = clr_ff;
            clr_in    = clr_ff + ADDR_W'(1);
         end
         S_IDLE: begin
            if (accept) begin
               xc_in   = req_data.x_centre;
               yc_in   = req_data.y_centre;
               flux_in = req_data.flux;
               fw_in   = req_data.fwhm_px;
               oor_in  = !((32'(req_data.read_col) < 32'(IMG_W)) &&
                           (32'(req_data.read_row) < 32'(IMG_H)));
               img_raddr = rd_addr;
               img_re    = (req_data.opcode == OP_READ);
               if (req_data.opcode == OP_RENDER && skip_arg) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.status = ST_BAD_ARG;
               end
            end
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_in.status = ST_READ;
            rsp_in.pixel_value = oor_ff ? 32'd0 : img_rd_ff;
         end
         S_SETUP: begin
            rad_prod_in = RAD_PROD_W'(fw_ff * RADIUS_K_Q16);
         end
         S_WIN: begin
            x0_in  = (cx - r_ext < 0) ? '0 : cx - r_ext;
            y0_in  = (cy - r_ext < 0) ? '0 : cy - r_ext;
            x1_in  = (cx + r_ext + CRD_W'(1) > IMG_W_S) ? IMG_W_S : cx + r_ext + CRD_W'(1);
            y1_in  = (cy + r_ext + CRD_W'(1) > IMG_H_S) ? IMG_H_S : cy + r_ext + CRD_W'(1);
            den_in = DEN_W'(fw_ff * fw_ff) << 8;
         end
         S_CHK: begin
            px_in = x0_ff; py_in = y0_ff; idx_in = '0; wsum_in = '0;
            if (x0_ff >= x1_ff || y0_ff >= y1_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = ST_OUTSIDE;
            end
         end
         S_P1_DXY: begin
            ax_in = AX_W'(dx < 0 ? -dx : dx);
            ay_in = AX_W'(dy < 0 ? -dy : dy);
         end
         S_P1_SQX: sq_in = ax_ff * ax_ff;
         S_P1_SQY: d2_in = D2_W'(sq_ff) + D2_W'(ay_ff * ay_ff);
         S_P1_NUM: num_in = DIV_W'(d2_ff * EXP_IDX_K);
         S_P1_CHK: begin
            wzero_in = num_ff >= (DIV_W'(den_ff) << EXP_AW);
            dsh_in   = DIV_W'(den_ff) << (EXP_AW - 1);
            q_in     = '0;
            cnt_in   = CNT_W'(EXP_AW - 1);
         end
         S_P1_DIV, S_P2_DIV, S_P1_ROM, S_P2_RD: begin
            img_re = (state_ff == S_P2_RD);
         end
         S_P1_ACC: begin
            w_we    = 1'b1;
            wsum_in = wsum_next;
            if (last_pix) begin
               px_in = x0_ff; py_in = y0_ff; idx_in = '0;
               if (wsum_next == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in.status = ST_BAD_ARG;
               end
            end
         end
         S_P2_MUL: num_in = DIV_W'(flux_ff * w_rd_ff);
         S_P2_DIVS: begin
            dsh_in = DIV_W'(wsum_ff) << (Q_W - 1);
            q_in   = '0;
            cnt_in = CNT_W'(Q_W - 1);
         end
         S_P2_WR: begin
            img_we    = 1'b1;
            img_wdata = sum_sat[32] ? 32'hFFFF_FFFF : sum_sat[31:0];
            if (last_pix) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      xc_ff <= xc_in; yc_ff <= yc_in; flux_ff <= flux_in; fw_ff <= fw_in; oor_ff <= oor_in;
      rad_prod_ff <= rad_prod_in; den_ff <= den_in;
      x0_ff <= x0_in; x1_ff <= x1_in; y0_ff <= y0_in; y1_ff <= y1_in;
      px_ff <= px_in; py_ff <= py_in; idx_ff <= idx_in;
      ax_ff <= ax_in; ay_ff <= ay_in; sq_ff <= sq_in; d2_ff <= d2_in;
      num_ff <= num_in; dsh_ff <= dsh_in; q_ff <= q_in; cnt_ff <= cnt_in;
      wzero_ff <= wzero_in; wsum_ff <= wsum_in;
      rsp_ff <= rsp_in;
   end

   // image memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (img_we) img_mem[img_waddr] <= img_wdata;
      if (img_re) img_rd_ff <= img_mem[img_raddr];
   end

   // window weight memory, written in pass one, read in pass two
   always_ff @(posedge clock) begin
      if (w_we) w_mem[idx_ff] <= w_sel;
      w_rd_ff <= w_mem[idx_ff];
   end

   // exponent table
   always_ff @(posedge clock) begin
      exp_rd_ff <= EXP_TAB[q_ff[EXP_AW-1:0]];
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // divider remainder stays below twice the shifted divisor
   `GPS_ASSERT_IMPL(a_div_bound, clock, reset,
      (state_ff == S_P1_DIV || state_ff == S_P2_DIV),
      ({1'b0, num_ff} < {dsh_ff, 1'b0}))
   // a single pixel weight never exceeds the window sum
   `GPS_ASSERT_IMPL(a_weight_le_sum, clock, reset, (state_ff == S_P2_MUL),
      (WS_W'(w_rd_ff) <= wsum_ff))
   // deposits never lower a pixel
   `GPS_ASSERT_IMPL(a_deposit_grows, clock, reset, (state_ff == S_P2_WR),
      (img_wdata >= img_rd_ff))
   // a read item in S_READ raises a registered ST_READ response
   `GPS_ASSERT_NEXT(a_read_answers, clock, reset, (state_ff == S_READ),
      (rsp_valid && rsp_data.status == ST_READ))

endmodule
